// File: rtl/csbm_pkg.sv
// ----------------------------------------------------------------------------
// csbm_pkg: column SAD block matcher shared definitions
// Sizes, pixel and SAD types, lane control word and pixel unpacking.
// ----------------------------------------------------------------------------
package csbm_pkg;

  localparam int BLOCK_HEIGHT = 5;
  localparam int SEARCH_RANGE = 3;
  localparam int PIXEL_BITS   = 4;

  localparam int OFF_NUM     = 2 * SEARCH_RANGE + 1;
  localparam int NCOLPIX     = BLOCK_HEIGHT + 2 * SEARCH_RANGE;
  localparam int COLUMN_BITS = 44;
  localparam int SHIFT_BITS  = 4;
  localparam int SAD_BITS    = 15;
  localparam int FLOW_BITS   = 6;
  localparam int FLOW_PART_BITS = 3;

  localparam int PIX_MAX   = (1 << PIXEL_BITS) - 1;
  localparam int COL_SAD_W = $clog2(BLOCK_HEIGHT * PIX_MAX + 1);
  localparam int BLK_SAD_W = $clog2(BLOCK_HEIGHT * BLOCK_HEIGHT * PIX_MAX + 1);
  localparam int IDX_W     = $clog2(OFF_NUM);

  localparam logic [SAD_BITS-1:0]   SAD_NONE   = 15'h7fff;
  localparam logic [FLOW_BITS-1:0]  FLOW_NONE  = 6'h3f;
  localparam logic [SHIFT_BITS-1:0] SHIFT_NEW  = '0;
  localparam logic [SHIFT_BITS-1:0] SHIFT_FULL = SHIFT_BITS'(BLOCK_HEIGHT - 1);

  typedef logic [PIXEL_BITS-1:0]  pixel_t;
  typedef logic [COLUMN_BITS-1:0] column_t;
  typedef logic [SHIFT_BITS-1:0]  shift_t;
  typedef logic [COL_SAD_W-1:0]   col_sad_t;
  typedef logic [BLK_SAD_W-1:0]   blk_sad_t;
  typedef logic [IDX_W-1:0]       off_idx_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic clear_b;
  } lane_ctl_t;

  function automatic pixel_t pixel_at(column_t col, int k);
    pixel_t r;
    r = '0;
    for (int b = 0; b < PIXEL_BITS; b++) begin
      if (PIXEL_BITS * k + b < COLUMN_BITS) begin
        r[b] = col[PIXEL_BITS * k + b];
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/csbm_if.sv
// ----------------------------------------------------------------------------
// csbm_if: column SAD block matcher channels
// Valid/ready channels for column beats in and match beats out.
// ----------------------------------------------------------------------------
interface csbm_in_if;
  logic              valid;
  logic              ready;
  csbm_pkg::column_t ref_column;
  csbm_pkg::column_t tag_column;
  csbm_pkg::shift_t  shift_index;

  modport source (output valid, ref_column, tag_column, shift_index, input ready);
  modport sink   (input valid, ref_column, tag_column, shift_index, output ready);
endinterface

interface csbm_out_if;
  logic                               valid;
  logic                               ready;
  logic [csbm_pkg::SAD_BITS-1:0]      best_sad;
  logic [csbm_pkg::FLOW_BITS-1:0]     flow_code;

  modport source (output valid, best_sad, flow_code, input ready);
  modport sink   (input valid, best_sad, flow_code, output ready);
endinterface

// File: rtl/csbm_lane.sv
// ----------------------------------------------------------------------------
// csbm_lane: one vertical offset lane
// Column SAD, window of recent column SADs and registered block SAD.
// ----------------------------------------------------------------------------
module csbm_lane (
  input  logic                clk,
  input  logic                rst,
  input  csbm_pkg::lane_ctl_t ctl,
  input  csbm_pkg::pixel_t    ref_pix [csbm_pkg::BLOCK_HEIGHT],
  input  csbm_pkg::pixel_t    tag_pix [csbm_pkg::BLOCK_HEIGHT],
  output csbm_pkg::blk_sad_t  block_sum
);

  csbm_pkg::col_sad_t col_sad_next;
  csbm_pkg::col_sad_t col_sad;
  csbm_pkg::col_sad_t win [csbm_pkg::BLOCK_HEIGHT];
  csbm_pkg::blk_sad_t block_sum_next;

  always_comb begin
    csbm_pkg::pixel_t diff;
    col_sad_next = '0;
    for (int j = 0; j < csbm_pkg::BLOCK_HEIGHT; j++) begin
      diff = (ref_pix[j] >= tag_pix[j]) ? (ref_pix[j] - tag_pix[j])
                                        : (tag_pix[j] - ref_pix[j]);
      col_sad_next = col_sad_next + csbm_pkg::COL_SAD_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      col_sad <= col_sad_next;
    end
  end

  always_comb begin
    block_sum_next = csbm_pkg::BLK_SAD_W'(col_sad);
    if (!ctl.clear_b) begin
      for (int j = 1; j < csbm_pkg::BLOCK_HEIGHT; j++) begin
        block_sum_next = block_sum_next + csbm_pkg::BLK_SAD_W'(win[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < csbm_pkg::BLOCK_HEIGHT; j++) begin
        win[j] <= '0;
      end
    end else if (ctl.load_b) begin
      for (int j = 0; j < csbm_pkg::BLOCK_HEIGHT - 1; j++) begin
        win[j] <= ctl.clear_b ? '0 : win[j+1];
      end
      win[csbm_pkg::BLOCK_HEIGHT-1] <= col_sad;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_b) begin
      block_sum <= block_sum_next;
    end
  end

endmodule

// File: rtl/csbm_merge.sv
// ----------------------------------------------------------------------------
// csbm_merge: lane merge and best match
// Registered minimum over the lanes, then update of the kept best match.
// ----------------------------------------------------------------------------
module csbm_merge (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load_c,
  input  logic                            load_d,
  input  csbm_pkg::shift_t                shift,
  input  csbm_pkg::blk_sad_t              block_sum [csbm_pkg::OFF_NUM],
  output logic [csbm_pkg::SAD_BITS-1:0]   best_sad,
  output logic [csbm_pkg::FLOW_BITS-1:0]  flow_code
);

  csbm_pkg::blk_sad_t min_val_next;
  csbm_pkg::off_idx_t min_idx_next;
  csbm_pkg::blk_sad_t min_val;
  csbm_pkg::off_idx_t min_idx;
  logic [csbm_pkg::SAD_BITS-1:0]       base_sad;
  logic [csbm_pkg::FLOW_BITS-1:0]      base_flow;
  logic [csbm_pkg::SAD_BITS-1:0]       best_sad_next;
  logic [csbm_pkg::FLOW_BITS-1:0]      flow_code_next;
  logic [csbm_pkg::FLOW_PART_BITS-1:0] flow_x;

  always_comb begin
    min_val_next = block_sum[0];
    min_idx_next = '0;
    for (int d = 1; d < csbm_pkg::OFF_NUM; d++) begin
      if (block_sum[d] < min_val_next) begin
        min_val_next = block_sum[d];
        min_idx_next = csbm_pkg::IDX_W'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_c) begin
      min_val <= min_val_next;
      min_idx <= min_idx_next;
    end
  end

  always_comb begin
    base_sad  = (shift == csbm_pkg::SHIFT_NEW) ? csbm_pkg::SAD_NONE  : best_sad;
    base_flow = (shift == csbm_pkg::SHIFT_NEW) ? csbm_pkg::FLOW_NONE : flow_code;
    flow_x    = csbm_pkg::FLOW_PART_BITS'(shift - csbm_pkg::SHIFT_FULL);
    best_sad_next  = base_sad;
    flow_code_next = base_flow;
    if (shift >= csbm_pkg::SHIFT_FULL &&
        csbm_pkg::SAD_BITS'(min_val) < base_sad) begin
      best_sad_next  = csbm_pkg::SAD_BITS'(min_val);
      flow_code_next = {csbm_pkg::FLOW_PART_BITS'(min_idx), flow_x};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_sad  <= csbm_pkg::SAD_NONE;
      flow_code <= csbm_pkg::FLOW_NONE;
    end else if (load_d) begin
      best_sad  <= best_sad_next;
      flow_code <= flow_code_next;
    end
  end

endmodule

// File: rtl/column_sad_block_match.sv
// ----------------------------------------------------------------------------
// column_sad_block_match: column-wise SAD block matcher
// Seven offset lanes form column and block SADs; a merge stage keeps the best.
// ----------------------------------------------------------------------------
// Stages from column beat to match beat: column SAD, window and block SAD,
// lane minimum, best update.
// Throughput: one column beat per cycle; each stage holds only when its
// successor is full and stalled, so bubbles are absorbed under backpressure.
// Reset: empties the pipeline, zeroes every window, sets best SAD to 0x7fff
// and flow code to 63.
module column_sad_block_match (
  input logic       clk,
  input logic       rst,
  csbm_in_if.sink   col_in,
  csbm_out_if.source match_out
);

  logic a_valid, b_valid, c_valid, d_valid;
  logic ready_a, ready_b, ready_c, ready_d;
  logic load_a, load_b, load_c, load_d;
  csbm_pkg::shift_t    shift_a, shift_b, shift_c;
  csbm_pkg::lane_ctl_t lane_ctl;
  csbm_pkg::pixel_t    ref_pix [csbm_pkg::BLOCK_HEIGHT];
  csbm_pkg::blk_sad_t  block_sum [csbm_pkg::OFF_NUM];

  assign ready_d = !d_valid || match_out.ready;
  assign ready_c = !c_valid || ready_d;
  assign ready_b = !b_valid || ready_c;
  assign ready_a = !a_valid || ready_b;
  assign load_a  = col_in.valid && ready_a;
  assign load_b  = a_valid && ready_b;
  assign load_c  = b_valid && ready_c;
  assign load_d  = c_valid && ready_d;

  assign col_in.ready    = ready_a;
  assign match_out.valid = d_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (ready_a) a_valid <= col_in.valid;
      if (ready_b) b_valid <= a_valid;
      if (ready_c) c_valid <= b_valid;
      if (ready_d) d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) shift_a <= col_in.shift_index;
    if (load_b) shift_b <= shift_a;
    if (load_c) shift_c <= shift_b;
  end

  always_comb begin
    lane_ctl.load_a  = load_a;
    lane_ctl.load_b  = load_b;
    lane_ctl.clear_b = (shift_a == csbm_pkg::SHIFT_NEW);
  end

  always_comb begin
    for (int j = 0; j < csbm_pkg::BLOCK_HEIGHT; j++) begin
      ref_pix[j] = csbm_pkg::pixel_at(col_in.ref_column, j + csbm_pkg::SEARCH_RANGE);
    end
  end

  for (genvar d = 0; d < csbm_pkg::OFF_NUM; d++) begin : g_lane
    csbm_pkg::pixel_t tag_pix [csbm_pkg::BLOCK_HEIGHT];

    always_comb begin
      for (int j = 0; j < csbm_pkg::BLOCK_HEIGHT; j++) begin
        tag_pix[j] = csbm_pkg::pixel_at(col_in.tag_column, d + j);
      end
    end

    csbm_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (lane_ctl),
      .ref_pix   (ref_pix),
      .tag_pix   (tag_pix),
      .block_sum (block_sum[d])
    );
  end

  csbm_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load_c    (load_c),
    .load_d    (load_d),
    .shift     (shift_c),
    .block_sum (block_sum),
    .best_sad  (match_out.best_sad),
    .flow_code (match_out.flow_code)
  );

  a_none_pair: assert property (@(posedge clk) disable iff (rst)
    (match_out.best_sad == csbm_pkg::SAD_NONE) ==
    (match_out.flow_code == csbm_pkg::FLOW_NONE))
    else $error("best SAD and flow code disagree on no-match");

  a_monotonic: assert property (@(posedge clk) disable iff (rst)
    load_d && shift_c != csbm_pkg::SHIFT_NEW |=>
    match_out.best_sad <= $past(match_out.best_sad))
    else $error("best SAD grew within a match");

  a_not_full: assert property (@(posedge clk) disable iff (rst)
    load_d && shift_c < csbm_pkg::SHIFT_FULL |=>
    match_out.best_sad == (($past(shift_c) == csbm_pkg::SHIFT_NEW) ?
                           csbm_pkg::SAD_NONE : $past(match_out.best_sad)))
    else $error("best SAD replaced before window filled");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: column SAD block matcher testbench
// Streams column beats through the matcher under several idle and stall
// patterns. Every accepted beat is run through a local best-match model,
// and each match beat is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_top;
  import csbm_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int NUM_ROWS     = 25;

  localparam column_t COL_ZERO = '0;
  localparam column_t COL_ONES = '1;
  localparam column_t TIE_TAG  = 44'hF000000000F;

  typedef struct packed {
    logic [SAD_BITS-1:0]  sad;
    logic [FLOW_BITS-1:0] flow;
  } match_t;

  typedef struct packed {
    column_t              refc;
    column_t              tagc;
    shift_t               shift;
    logic                 known;
    logic [SAD_BITS-1:0]  sad;
    logic [FLOW_BITS-1:0] flow;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  csbm_in_if  col_in ();
  csbm_out_if match_out ();

  column_sad_block_match dut (
    .clk       (clk),
    .rst       (rst),
    .col_in    (col_in),
    .match_out (match_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{COL_ZERO, COL_ZERO, 4'd0, 1'b1, SAD_NONE, FLOW_NONE},
    '{COL_ZERO, COL_ZERO, 4'd1, 1'b1, SAD_NONE, FLOW_NONE},
    '{COL_ZERO, COL_ZERO, 4'd2, 1'b1, SAD_NONE, FLOW_NONE},
    '{COL_ZERO, COL_ZERO, 4'd3, 1'b1, SAD_NONE, FLOW_NONE},
    '{COL_ZERO, COL_ZERO, 4'd4, 1'b1, 15'd0, 6'd0},
    '{COL_ONES, COL_ONES, 4'd5, 1'b1, 15'd0, 6'd0},
    '{COL_ONES, COL_ZERO, 4'd0, 1'b1, SAD_NONE, FLOW_NONE},
    '{COL_ONES, COL_ZERO, 4'd1, 1'b1, SAD_NONE, FLOW_NONE},
    '{COL_ONES, COL_ZERO, 4'd2, 1'b1, SAD_NONE, FLOW_NONE},
    '{COL_ONES, COL_ZERO, 4'd3, 1'b1, SAD_NONE, FLOW_NONE},
    '{COL_ONES, COL_ZERO, 4'd4, 1'b1, 15'd375, 6'd0},
    '{COL_ONES, COL_ZERO, 4'd15, 1'b1, 15'd375, 6'd0},
    '{COL_ZERO, TIE_TAG, 4'd0, 1'b1, SAD_NONE, FLOW_NONE},
    '{COL_ZERO, TIE_TAG, 4'd1, 1'b1, SAD_NONE, FLOW_NONE},
    '{COL_ZERO, TIE_TAG, 4'd2, 1'b1, SAD_NONE, FLOW_NONE},
    '{COL_ZERO, TIE_TAG, 4'd3, 1'b1, SAD_NONE, FLOW_NONE},
    '{COL_ZERO, TIE_TAG, 4'd4, 1'b1, 15'd0, 6'd8},
    '{COL_ZERO, TIE_TAG, 4'd10, 1'b1, 15'd0, 6'd8},
    '{44'h123456789AB, 44'h23456789ABC, 4'd0, 1'b0, 15'd0, 6'd0},
    '{44'h0F1E2D3C4B5, 44'h1E2D3C4B5A6, 4'd7, 1'b0, 15'd0, 6'd0},
    '{44'h3C3C3C3C3C3, 44'hC3C3C3C3C3C, 4'd9, 1'b0, 15'd0, 6'd0},
    '{44'h5555555555A, 44'h5555555555A, 4'd11, 1'b0, 15'd0, 6'd0},
    '{44'h5555555555A, 44'h555555555A5, 4'd12, 1'b0, 15'd0, 6'd0},
    '{44'hA5A5A5A5A5A, 44'h5A5A5A5A5A5, 4'd14, 1'b0, 15'd0, 6'd0},
    '{44'h5555555555A, 44'h5555555555A, 4'd15, 1'b0, 15'd0, 6'd0}
  };

  col_sad_t             sad_window [BLOCK_HEIGHT][OFF_NUM];
  logic [SAD_BITS-1:0]  best_sad_q;
  logic [FLOW_BITS-1:0] best_flow_q;
  match_t               pending_matches [$];

  logic                 row_known;
  logic [SAD_BITS-1:0]  row_sad;
  logic [FLOW_BITS-1:0] row_flow;

  int src_idle_pct;
  int sink_stall_pct;
  int items_sent;
  int mismatches;
  int cycle_count;

  function automatic void advance_matcher(input column_t refc, input column_t tagc,
                                          input shift_t shift,
                                          output logic [SAD_BITS-1:0] sad,
                                          output logic [FLOW_BITS-1:0] flow);
    int                        acc;
    int                        a;
    int                        b;
    blk_sad_t                  blk;
    blk_sad_t                  min_sad;
    off_idx_t                  min_off;
    logic [FLOW_PART_BITS-1:0] fx;
    if (shift == SHIFT_NEW) begin
      for (int j = 0; j < BLOCK_HEIGHT; j++) begin
        for (int d = 0; d < OFF_NUM; d++) begin
          sad_window[j][d] = '0;
        end
      end
      best_sad_q  = SAD_NONE;
      best_flow_q = FLOW_NONE;
    end
    for (int j = 0; j < BLOCK_HEIGHT - 1; j++) begin
      for (int d = 0; d < OFF_NUM; d++) begin
        sad_window[j][d] = sad_window[j + 1][d];
      end
    end
    for (int d = 0; d < OFF_NUM; d++) begin
      acc = 0;
      for (int j = 0; j < BLOCK_HEIGHT; j++) begin
        a = int'(refc[PIXEL_BITS * (j + SEARCH_RANGE) +: PIXEL_BITS]);
        b = int'(tagc[PIXEL_BITS * (d + j) +: PIXEL_BITS]);
        acc += (a >= b) ? (a - b) : (b - a);
      end
      sad_window[BLOCK_HEIGHT - 1][d] = col_sad_t'(acc);
    end
    min_sad = '0;
    min_off = '0;
    for (int d = 0; d < OFF_NUM; d++) begin
      acc = 0;
      for (int j = 0; j < BLOCK_HEIGHT; j++) begin
        acc += int'(sad_window[j][d]);
      end
      blk = blk_sad_t'(acc);
      if (d == 0 || blk < min_sad) begin
        min_sad = blk;
        min_off = off_idx_t'(d);
      end
    end
    if (shift >= SHIFT_FULL && SAD_BITS'(min_sad) < best_sad_q) begin
      fx          = FLOW_PART_BITS'(shift - SHIFT_FULL);
      best_sad_q  = SAD_BITS'(min_sad);
      best_flow_q = {FLOW_PART_BITS'(min_off), fx};
    end
    sad  = best_sad_q;
    flow = best_flow_q;
  endfunction

  function automatic column_t random_column();
    int mode;
    mode = $urandom_range(7);
    if (mode == 0) return COL_ZERO;
    if (mode == 1) return COL_ONES;
    return column_t'({$urandom(), $urandom()});
  endfunction

  function automatic column_t target_near(column_t refc);
    int      mode;
    int      d;
    column_t moved;
    column_t noise;
    mode = $urandom_range(9);
    if (mode < 3) return random_column();
    d = $urandom_range(2 * SEARCH_RANGE);
    if (d >= SEARCH_RANGE) moved = refc << (PIXEL_BITS * (d - SEARCH_RANGE));
    else moved = refc >> (PIXEL_BITS * (SEARCH_RANGE - d));
    noise = column_t'({$urandom(), $urandom()}) & column_t'({$urandom(), $urandom()})
            & {NCOLPIX{4'h1}};
    if (mode < 6) noise = '0;
    return moved ^ noise;
  endfunction

  task automatic send_column(input column_t refc, input column_t tagc, input shift_t shift,
                             input logic known, input logic [SAD_BITS-1:0] sad,
                             input logic [FLOW_BITS-1:0] flow);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      col_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    col_in.valid       <= 1'b1;
    col_in.ref_column  <= refc;
    col_in.tag_column  <= tagc;
    col_in.shift_index <= shift;
    row_known          <= known;
    row_sad            <= sad;
    row_flow           <= flow;
    @(posedge clk);
    while (!col_in.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random(input shift_t shift);
    column_t refc;
    refc = random_column();
    send_column(refc, target_near(refc), shift, 1'b0, '0, '0);
  endtask

  always @(posedge clk) begin
    match_out.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    match_t want;
    if (!rst) begin
      if (col_in.valid && col_in.ready) begin
        advance_matcher(col_in.ref_column, col_in.tag_column, col_in.shift_index,
                        want.sad, want.flow);
        if (row_known) begin
          want.sad  = row_sad;
          want.flow = row_flow;
        end
        pending_matches.push_back(want);
      end
      if (match_out.valid && match_out.ready) begin
        if (pending_matches.size() == 0) begin
          $error("unexpected match beat: best_sad %0d flow_code %0d",
                 match_out.best_sad, match_out.flow_code);
          mismatches++;
        end else begin
          want = pending_matches.pop_front();
          if (match_out.best_sad !== want.sad) begin
            $error("best_sad: expected %0d, got %0d", want.sad, match_out.best_sad);
            mismatches++;
          end
          if (match_out.flow_code !== want.flow) begin
            $error("flow_code: expected %0d, got %0d", want.flow, match_out.flow_code);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    int kind;
    int len;
    int phase;
    int step;
    shift_t shift;
    rst                = 1'b1;
    col_in.valid       = 1'b0;
    col_in.ref_column  = '0;
    col_in.tag_column  = '0;
    col_in.shift_index = '0;
    match_out.ready    = 1'b0;
    row_known          = 1'b0;
    row_sad            = '0;
    row_flow           = '0;
    src_idle_pct       = 0;
    sink_stall_pct     = 0;
    items_sent         = 0;
    mismatches         = 0;
    cycle_count        = 0;
    best_sad_q         = SAD_NONE;
    best_flow_q        = FLOW_NONE;
    for (int j = 0; j < BLOCK_HEIGHT; j++) begin
      for (int d = 0; d < OFF_NUM; d++) begin
        sad_window[j][d] = '0;
      end
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_column(directed_rows[i].refc, directed_rows[i].tagc, directed_rows[i].shift,
                  directed_rows[i].known, directed_rows[i].sad, directed_rows[i].flow);
    end

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      phase = items_sent * 4 / RANDOM_ITEMS;
      case (phase)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 63;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 63;
        end
        default: begin
          src_idle_pct   = 6;
          sink_stall_pct = 6;
        end
      endcase
      kind = $urandom_range(9);
      if (kind <= 6) begin
        len = $urandom_range(BLOCK_HEIGHT, 11);
        for (int i = 0; i < len; i++) send_random(shift_t'(i));
      end else if (kind == 7) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) send_random(shift_t'($urandom_range(15)));
      end else if (kind == 8) begin
        shift = SHIFT_NEW;
        len   = $urandom_range(2, 8);
        for (int i = 0; i < len; i++) begin
          send_random(shift);
          step  = $urandom_range(3);
          shift = shift + shift_t'(step);
        end
      end else begin
        for (int i = 0; i < 16; i++) send_random(shift_t'(i));
      end
    end
    col_in.valid <= 1'b0;

    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
